// ===== design/pmce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pager message codeword encoder package
// Shared widths, constants, result types and helper functions for the
// character packer, the BCH(31,21) encoder and the result queue.
// ----------------------------------------------------------------------------
package pmce_pkg;

  // Payload and packer widths.
  localparam int ACC_W  = 20;
  localparam int FILL_W = 5;
  localparam int CHAR_W = 8;
  localparam int CW_W   = 32;
  localparam int REM_W  = 10;
  localparam int DATA_W = ACC_W + 1;

  // BCH(31,21) generator polynomial.
  localparam logic [REM_W:0] BCH_GEN = 11'h769;

  // Numeric pad code 0x3 repeated over a whole payload.
  localparam logic [ACC_W-1:0] PAD_PATTERN = 20'h33333;

  // Result queue depth and count width.
  localparam int QUEUE_DEPTH = 3;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One result item.
  typedef struct packed {
    logic [CW_W-1:0] codeword;
    logic            last_word;
    logic            bad_char;
  } res_t;

  // Up to two results produced by one accepted character.
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

  // Numeric character code: bit 4 set when the character is valid.
  function automatic logic [4:0] numeric_code(input logic [CHAR_W-1:0] c);
    logic [4:0] code;
    case (c)
      8'h30: code = 5'h10; // '0'
      8'h31: code = 5'h18; // '1'
      8'h32: code = 5'h14; // '2'
      8'h33: code = 5'h1C; // '3'
      8'h34: code = 5'h12; // '4'
      8'h35: code = 5'h1A; // '5'
      8'h36: code = 5'h16; // '6'
      8'h37: code = 5'h1E; // '7'
      8'h38: code = 5'h11; // '8'
      8'h39: code = 5'h19; // '9'
      8'h20: code = 5'h13; // space
      8'h55: code = 5'h1D; // 'U'
      8'h2D: code = 5'h1B; // '-'
      8'h5B, 8'h28: code = 5'h1F; // '[' and '('
      8'h5D, 8'h29: code = 5'h17; // ']' and ')'
      8'h53, 8'h45: code = 5'h15; // 'S' and 'E'
      default: code = 5'h00;
    endcase
    return code;
  endfunction

  // Remainder of x^(i+10) modulo the generator, evaluated at elaboration.
  function automatic logic [REM_W-1:0] bch_bit_rem(input int i);
    logic [30:0] r;
    r = 31'(1) << (i + REM_W);
    for (int k = 30; k >= REM_W; k--) begin
      if (r[k]) begin
        r = r ^ (31'(BCH_GEN) << (k - REM_W));
      end
    end
    return r[REM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/pmce_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pager message codeword encoder channels
// Character input channel and codeword output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pmce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_message;

  modport source (output valid, output char_code, output end_of_message, input ready);
  modport sink (input valid, input char_code, input end_of_message, output ready);
endinterface

interface pmce_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] codeword;
  logic        last_word;
  logic        bad_char;

  modport source (output valid, output codeword, output last_word, output bad_char,
                  input ready);
  modport sink (input valid, input codeword, input last_word, input bad_char,
                output ready);
endinterface

`default_nettype wire

// ===== design/pmce_bch_enc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BCH(31,21) codeword encoder
// Builds flag, payload, ten systematic check bits and even parity from a
// 20-bit payload. The check bits are an XOR of per-bit remainders.
// ----------------------------------------------------------------------------
module pmce_bch_enc (
  input  wire logic [pmce_pkg::ACC_W-1:0] payload,
  output logic      [pmce_pkg::CW_W-1:0]  codeword
);

  logic [pmce_pkg::DATA_W-1:0] data;
  logic [pmce_pkg::REM_W-1:0]  terms [pmce_pkg::DATA_W];
  logic [pmce_pkg::REM_W-1:0]  check;
  logic [pmce_pkg::CW_W-1:0]   word_np;

  // Message flag on top of the payload.
  assign data = {1'b1, payload};

  // Each data bit contributes its fixed remainder.
  for (genvar g = 0; g < pmce_pkg::DATA_W; g++) begin : g_term
    localparam logic [pmce_pkg::REM_W-1:0] SYN = pmce_pkg::bch_bit_rem(g);
    assign terms[g] = data[g] ? SYN : '0;
  end

  always_comb begin
    check = '0;
    for (int i = 0; i < pmce_pkg::DATA_W; i++) begin
      check = check ^ terms[i];
    end
  end

  // Word without parity, then even parity in the LSB.
  assign word_np  = {data, check, 1'b0};
  assign codeword = {word_np[pmce_pkg::CW_W-1:1], ^word_np};

endmodule

`default_nettype wire

// ===== design/pmce_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Message character packer
// Holds the mode register and the partial payload, folds one character per
// transfer into it and produces up to two encoded results.
// ----------------------------------------------------------------------------
module pmce_packer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  pmce_in_if.sink            char_in,
  input  wire logic          space,
  output pmce_pkg::push_t    push
);

  logic                         alpha_mode;
  logic [pmce_pkg::ACC_W-1:0]   acc;
  logic [pmce_pkg::FILL_W-1:0]  fill;
  logic [pmce_pkg::ACC_W-1:0]   acc_next;
  logic [pmce_pkg::FILL_W-1:0]  fill_next;

  logic                         accept;
  logic                         eom;
  logic [4:0]                   code_info;
  logic                         num_bad;
  logic [6:0]                   rev7;
  logic [7:0]                   seq;
  logic [3:0]                   seq_n;
  logic [pmce_pkg::FILL_W-1:0]  total;
  logic [pmce_pkg::ACC_W+7:0]   v;
  logic                         full;
  logic [2:0]                   excess;
  logic [pmce_pkg::ACC_W-1:0]   p_full;
  logic [pmce_pkg::FILL_W-1:0]  rem_cnt;
  logic [pmce_pkg::ACC_W-1:0]   rem_val;
  logic [pmce_pkg::FILL_W-1:0]  pad_sh;
  logic [pmce_pkg::ACC_W-1:0]   p_tail;
  logic                         have_tail;
  logic [pmce_pkg::ACC_W-1:0]   enc0_in;
  logic [pmce_pkg::CW_W-1:0]    cw0;
  logic [pmce_pkg::CW_W-1:0]    cw1;

  assign char_in.ready = space;
  assign accept        = char_in.valid && space;
  assign eom           = char_in.end_of_message;
  assign code_info     = pmce_pkg::numeric_code(char_in.char_code);
  assign num_bad       = !alpha_mode && !code_info[4];

  // Alpha characters go out LSB first, so the first bit lands highest.
  for (genvar g = 0; g < 7; g++) begin : g_rev
    assign rev7[g] = char_in.char_code[6 - g];
  end

  // Append the new bits and split off a complete word.
  always_comb begin
    if (alpha_mode) begin
      seq   = eom ? {rev7, 1'b1} : {1'b0, rev7};
      seq_n = eom ? 4'd8 : 4'd7;
    end else begin
      seq   = {4'b0, code_info[3:0]};
      seq_n = 4'd4;
    end
    total   = fill + pmce_pkg::FILL_W'(seq_n);
    v       = ({8'b0, acc} << seq_n) | {20'b0, seq};
    full    = total >= pmce_pkg::FILL_W'(pmce_pkg::ACC_W);
    excess  = full ? 3'(total - pmce_pkg::FILL_W'(pmce_pkg::ACC_W)) : 3'd0;
    p_full  = pmce_pkg::ACC_W'(v >> excess);
    rem_cnt = full ? {2'b0, excess} : total;
    rem_val = full ? pmce_pkg::ACC_W'(v & ~({(pmce_pkg::ACC_W + 8){1'b1}} << excess))
                   : v[pmce_pkg::ACC_W-1:0];
  end

  // Tail word at message end: left-justify, then pad in numeric mode.
  always_comb begin
    pad_sh    = pmce_pkg::FILL_W'(pmce_pkg::ACC_W) - rem_cnt;
    p_tail    = rem_val << pad_sh;
    if (!alpha_mode) begin
      p_tail = p_tail | (pmce_pkg::PAD_PATTERN & ~({pmce_pkg::ACC_W{1'b1}} << pad_sh));
    end
    have_tail = eom && (rem_cnt != '0);
  end

  // Packer state after this character.
  always_comb begin
    if (eom || num_bad) begin
      acc_next  = '0;
      fill_next = '0;
    end else begin
      acc_next  = rem_val;
      fill_next = rem_cnt;
    end
  end

  assign enc0_in = full ? p_full : p_tail;

  pmce_bch_enc u_enc0 (
    .payload  (enc0_in),
    .codeword (cw0)
  );

  pmce_bch_enc u_enc1 (
    .payload  (p_tail),
    .codeword (cw1)
  );

  // Results handed to the queue.
  always_comb begin
    push.res1.codeword  = cw1;
    push.res1.last_word = 1'b1;
    push.res1.bad_char  = 1'b0;
    if (num_bad) begin
      push.count          = accept ? 2'd1 : 2'd0;
      push.res0.codeword  = '0;
      push.res0.last_word = eom;
      push.res0.bad_char  = 1'b1;
    end else begin
      push.count          = accept ? ({1'b0, full} + {1'b0, have_tail}) : 2'd0;
      push.res0.codeword  = cw0;
      push.res0.last_word = eom && !(full && have_tail);
      push.res0.bad_char  = 1'b0;
    end
  end

  // Mode register and packer state; a mode write empties the packer.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_mode <= 1'b0;
      acc        <= '0;
      fill       <= '0;
    end else if (cfg_we) begin
      alpha_mode <= cfg_wdata;
      acc        <= '0;
      fill       <= '0;
    end else if (accept) begin
      acc        <= acc_next;
      fill       <= fill_next;
    end
  end

`ifndef SYNTHESIS
  // A partial word never holds a whole payload.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill < pmce_pkg::FILL_W'(pmce_pkg::ACC_W))
    else $error("packer fill count reached a full payload");

  // Numeric packing stays on nibble boundaries.
  a_numeric_nibble: assert property (@(posedge clk) disable iff (rst)
    !alpha_mode |-> (fill[1:0] == 2'b00))
    else $error("numeric fill count is not nibble aligned");

  // Two results only come at alpha message end, and only the second is last.
  a_two_results: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (alpha_mode && eom && push.res1.last_word
                              && !push.res0.last_word))
    else $error("two results without alpha message end ordering");
`endif

endmodule

`default_nettype wire

// ===== design/pmce_result_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Three-entry shift queue between the packer and the output channel. Takes
// up to two results per cycle when it has room and presents the oldest.
// ----------------------------------------------------------------------------
module pmce_result_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  pmce_pkg::push_t    push,
  output logic               space,
  pmce_out_if.source         word_out
);

  pmce_pkg::res_t               q      [pmce_pkg::QUEUE_DEPTH];
  pmce_pkg::res_t               q_next [pmce_pkg::QUEUE_DEPTH];
  logic [pmce_pkg::QCNT_W-1:0]  count;
  logic [pmce_pkg::QCNT_W-1:0]  count_next;
  logic [pmce_pkg::QCNT_W-1:0]  base;
  logic                         pop;

  // Room for two results keeps the input free of any path from the output.
  assign space = count <= pmce_pkg::QCNT_W'(pmce_pkg::QUEUE_DEPTH - 2);

  assign word_out.valid     = count != '0;
  assign word_out.codeword  = q[0].codeword;
  assign word_out.last_word = q[0].last_word;
  assign word_out.bad_char  = q[0].bad_char;

  assign pop        = word_out.valid && word_out.ready;
  assign base       = count - pmce_pkg::QCNT_W'(pop);
  assign count_next = base + pmce_pkg::QCNT_W'(push.count);

  // Shift down on a transfer out, then place new results behind the rest.
  always_comb begin
    for (int i = 0; i < pmce_pkg::QUEUE_DEPTH; i++) begin
      q_next[i] = q[i];
      if (pmce_pkg::QCNT_W'(i) < base) begin
        if (pop && (i + 1 < pmce_pkg::QUEUE_DEPTH)) begin
          q_next[i] = q[i + 1];
        end
      end else if ((pmce_pkg::QCNT_W'(i) == base) && (push.count != 2'd0)) begin
        q_next[i] = push.res0;
      end else if ((pmce_pkg::QCNT_W'(i) == base + pmce_pkg::QCNT_W'(1))
                   && (push.count == 2'd2)) begin
        q_next[i] = push.res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < pmce_pkg::QUEUE_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

`ifndef SYNTHESIS
  // Pushes never overrun the queue.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= pmce_pkg::QCNT_W'(pmce_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // An error result never carries a codeword.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (word_out.valid && word_out.bad_char) |-> (word_out.codeword == '0))
    else $error("error result with nonzero codeword");
`endif

endmodule

`default_nettype wire

// ===== design/pager_message_codeword_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pager message codeword encoder
// Packs message characters into 32-bit pager message codewords with BCH
// check bits and even parity.
// ----------------------------------------------------------------------------
// The block takes one character per clock while its input is ready; results
// are registered in the queue and shown on the output channel behind older
// ones. Most characters give no result or one; in alpha mode a final
// character that completes a word and starts another gives two, which leave
// as two output words. Results wait in a three-entry queue, and the input is
// ready while that queue holds at most one result, so a character that yields
// two results costs an input stall when the output drains one word per cycle.
// Writing alpha_mode (cfg_wdata, taken when cfg_we is high) selects the
// packing mode and drops any partial word; write it only between messages.
module pager_message_codeword_encoder (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata,
  pmce_in_if.sink     char_in,
  pmce_out_if.source  word_out
);

  pmce_pkg::push_t push;
  logic            space;

  // Character packing and encoding.
  pmce_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .char_in   (char_in),
    .space     (space),
    .push      (push)
  );

  // Result buffering toward the output channel.
  pmce_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space    (space),
    .word_out (word_out)
  );

endmodule

`default_nettype wire
